FILE: hw/rtl/ircbm_pkg.sv
// shared types and constants of the ir carrier burst modulator
package ircbm_pkg;

  localparam int WIDTH_W    = 8;
  localparam int HALF_W     = 6;
  localparam int DUR_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_HALF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_OFF     = 3'd4;

  localparam logic [WIDTH_W-1:0] WIDTH_FIRST_RST  = 8'd100;
  localparam logic [WIDTH_W-1:0] WIDTH_SECOND_RST = 8'd125;
  localparam logic [WIDTH_W-1:0] WIDTH_THIRD_RST  = 8'd175;
  localparam logic [HALF_W-1:0]  CARRIER_HALF_RST = 6'd13;
  localparam logic [WIDTH_W-1:0] TAIL_OFF_RST     = 8'd10;
  localparam logic [HALF_W-1:0]  HALF_MIN         = 6'd8;

  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic               bit_value;
    logic               last_bit;
    logic [WIDTH_W-1:0] bit_width;
    logic [HALF_W-1:0]  half;
    logic [WIDTH_W-1:0] tail;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

FILE: hw/rtl/ir_carrier_burst_modulator_top.sv
// ir carrier burst modulator: frame bits in, carrier on/off segments out
//
// input channel: one frame bit per transaction (in_bit_value, in_last_bit),
// taken when in_valid is high and in_stall is low. output channel: one
// segment per transaction (out_pin_level, out_delay_us, out_frame_end),
// taken when out_valid is high and out_stall is low.
// configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 width_first, 1 width_second, 2 width_third, 3 carrier_half_us,
// 4 tail_off_us); write only while the block is idle.
// the front end captures a bit with its width and settings into a short
// queue; the segment generator works one bit at a time and emits at most
// one segment per cycle into an output register.
// each bit passes the generator states idle, close, acc and last; a high bit
// also passes chop, with one segment per carrier half. a frame that ends on a
// high run adds a tail segment. a bit may emit no segment at all.
// reset restores the register defaults and starts a new frame.
// a stalled receiver holds the output register, which stops the generator
// and, once the queue fills, raises in_stall.
module ir_carrier_burst_modulator_top
  import ircbm_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_bit_value,
  input  logic                  in_last_bit,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_pin_level,
  output logic [DUR_W-1:0]      out_delay_us,
  output logic                  out_frame_end
);

  queue_stat_t q_stat;
  logic        push;
  logic        pop;
  item_t       push_item;
  item_t       pop_item;

  ircbm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_bit_value (in_bit_value),
    .in_last_bit  (in_last_bit),
    .q_stat       (q_stat),
    .push         (push),
    .push_item    (push_item)
  );

  ircbm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  ircbm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .pop_item      (pop_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pin_level (out_pin_level),
    .out_delay_us  (out_delay_us),
    .out_frame_end (out_frame_end)
  );

endmodule

FILE: hw/rtl/ircbm_front.sv
// front end: configuration registers, bit width pattern and item capture
module ircbm_front
  import ircbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_bit_value,
  input  logic                  in_last_bit,
  input  queue_stat_t           q_stat,
  output logic                  push,
  output item_t                 push_item
);

  logic [WIDTH_W-1:0] width_first_r;
  logic [WIDTH_W-1:0] width_second_r;
  logic [WIDTH_W-1:0] width_third_r;
  logic [HALF_W-1:0]  carrier_half_r;
  logic [WIDTH_W-1:0] tail_off_r;
  logic [1:0]         slot_r;
  logic [1:0]         slot_nxt;
  logic [WIDTH_W-1:0] cur_width;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_first_r  <= WIDTH_FIRST_RST;
      width_second_r <= WIDTH_SECOND_RST;
      width_third_r  <= WIDTH_THIRD_RST;
      carrier_half_r <= CARRIER_HALF_RST;
      tail_off_r     <= TAIL_OFF_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WIDTH_FIRST:  width_first_r  <= cfg_data;
        REG_WIDTH_SECOND: width_second_r <= cfg_data;
        REG_WIDTH_THIRD:  width_third_r  <= cfg_data;
        REG_CARRIER_HALF: carrier_half_r <= cfg_data[HALF_W-1:0];
        REG_TAIL_OFF:     tail_off_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (slot_r)
      SLOT_FIRST:  cur_width = width_first_r;
      SLOT_SECOND: cur_width = width_second_r;
      default:     cur_width = width_third_r;
    endcase
  end

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    if (in_last_bit || slot_r >= SLOT_THIRD) begin
      slot_nxt = SLOT_FIRST;
    end else begin
      slot_nxt = slot_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= SLOT_FIRST;
    end else if (push) begin
      slot_r <= slot_nxt;
    end
  end

  always_comb begin
    push_item.bit_value = in_bit_value;
    push_item.last_bit  = in_last_bit;
    push_item.bit_width = cur_width;
    push_item.half      = (carrier_half_r < HALF_MIN) ? HALF_MIN : carrier_half_r;
    push_item.tail      = tail_off_r;
  end

endmodule

FILE: hw/rtl/ircbm_queue.sv
// short item queue between front end and segment generator
module ircbm_queue
  import ircbm_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  item_t       push_item,
  input  logic        pop,
  output item_t       pop_item,
  output queue_stat_t q_stat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t             slots_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r;
  logic [PtrW-1:0]   rd_ptr_r;
  logic [CntW-1:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign q_stat.full  = (count_r == CntW'(Depth));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_item     = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/ircbm_back.sv
// segment generator: run merging, carrier chopping and output register
module ircbm_back
  import ircbm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  queue_stat_t      q_stat,
  input  item_t            pop_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_pin_level,
  output logic [DUR_W-1:0] out_delay_us,
  output logic             out_frame_end
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLOSE = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_CHOP  = 3'd3;
  localparam logic [2:0] S_LAST  = 3'd4;
  localparam logic [2:0] S_TAIL  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  item_t            cur_r;
  logic             run_level_r, run_level_nxt;
  logic [DUR_W-1:0] run_time_r, run_time_nxt;
  logic             phase_r, phase_nxt;
  logic [HALF_W-1:0] carry_r, carry_nxt;

  logic             out_valid_r;
  logic             out_pin_level_r;
  logic [DUR_W-1:0] out_delay_r;
  logic             out_frame_end_r;

  logic             out_free;
  logic             emit;
  logic             emit_level;
  logic [DUR_W-1:0] emit_delay;
  logic             emit_end;
  logic [DUR_W:0]   low_close_sum;
  logic [DUR_W-1:0] low_close_dur;
  logic [DUR_W:0]   low_acc_sum;
  logic [DUR_W-1:0] half_ext;

  assign out_free      = !out_valid_r || !out_stall;
  assign half_ext      = DUR_W'(cur_r.half);
  assign low_close_sum = {1'b0, run_time_r} + (DUR_W + 1)'(carry_r);
  assign low_close_dur = low_close_sum[DUR_W] ? '1 : low_close_sum[DUR_W-1:0];
  assign low_acc_sum   = {1'b0, run_time_r} + (DUR_W + 1)'(cur_r.bit_width);
  assign pop           = (state_r == S_IDLE) && !q_stat.empty;

  always_comb begin
    state_nxt     = state_r;
    run_level_nxt = run_level_r;
    run_time_nxt  = run_time_r;
    phase_nxt     = phase_r;
    carry_nxt     = carry_r;
    emit          = 1'b0;
    emit_level    = 1'b0;
    emit_delay    = '0;
    emit_end      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (cur_r.bit_value == run_level_r) begin
          state_nxt = S_ACC;
        end else if (run_level_r && !phase_r) begin
          carry_nxt     = run_time_r[HALF_W-1:0];
          run_level_nxt = cur_r.bit_value;
          run_time_nxt  = '0;
          phase_nxt     = 1'b1;
          state_nxt     = S_ACC;
        end else if (out_free) begin
          emit          = 1'b1;
          emit_level    = run_level_r;
          emit_delay    = run_level_r ? run_time_r : low_close_dur;
          carry_nxt     = '0;
          run_level_nxt = cur_r.bit_value;
          run_time_nxt  = '0;
          phase_nxt     = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      S_ACC: begin
        if (run_level_r) begin
          run_time_nxt = low_acc_sum[DUR_W-1:0];
          state_nxt    = S_CHOP;
        end else begin
          run_time_nxt = low_acc_sum[DUR_W] ? '1 : low_acc_sum[DUR_W-1:0];
          state_nxt    = S_LAST;
        end
      end
      S_CHOP: begin
        if (run_time_r < half_ext) begin
          state_nxt = S_LAST;
        end else if (out_free) begin
          emit         = 1'b1;
          emit_level   = phase_r;
          emit_delay   = half_ext;
          phase_nxt    = !phase_r;
          run_time_nxt = run_time_r - half_ext;
        end
      end
      S_LAST: begin
        if (!cur_r.last_bit) begin
          state_nxt = S_IDLE;
        end else if (run_level_r && !phase_r) begin
          state_nxt = S_TAIL;
        end else if (out_free) begin
          emit       = 1'b1;
          emit_level = run_level_r;
          emit_delay = run_level_r ? run_time_r : low_close_dur;
          emit_end   = !run_level_r;
          if (run_level_r) begin
            state_nxt = S_TAIL;
          end else begin
            run_level_nxt = 1'b1;
            run_time_nxt  = '0;
            phase_nxt     = 1'b1;
            carry_nxt     = '0;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_level    = 1'b0;
          emit_delay    = DUR_W'(cur_r.tail);
          emit_end      = 1'b1;
          run_level_nxt = 1'b1;
          run_time_nxt  = '0;
          phase_nxt     = 1'b1;
          carry_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_level_r <= 1'b1;
      run_time_r  <= '0;
      phase_r     <= 1'b1;
      carry_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_level_r <= run_level_nxt;
      run_time_r  <= run_time_nxt;
      phase_r     <= phase_nxt;
      carry_r     <= carry_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_item;
    end
    if (emit) begin
      out_pin_level_r <= emit_level;
      out_delay_r     <= emit_delay;
      out_frame_end_r <= emit_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pin_level = out_pin_level_r;
  assign out_delay_us  = out_delay_r;
  assign out_frame_end = out_frame_end_r;

  // frame end segment is always an off segment
  a_end_is_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_end_r |-> !out_pin_level_r)
    else $error("frame end on an on segment");

  // chopped high run leaves less than one half-period
  a_high_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LAST) && run_level_r |-> run_time_r < half_ext)
    else $error("high run remainder not below half-period");

  // carried off-half remainder only lives in a low run
  a_carry_low: assert property (@(posedge clk) disable iff (!rst_n)
    carry_r != '0 |-> !run_level_r)
    else $error("carry present during high run");

  // no new segment overwrites one that is stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !emit)
    else $error("segment overwritten while stalled");

endmodule
